### rtl/hydrostatic_geopotential_column_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the geopotential column block
// Shared helpers for concurrent checks; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HYDROSTATIC_GEOPOTENTIAL_COLUMN_DEFINES_SVH
`define HYDROSTATIC_GEOPOTENTIAL_COLUMN_DEFINES_SVH

// same-cycle implication
`define HGC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hgc_pkg.sv
// ----------------------------------------------------------------------------
// hgc_pkg
// Widths, constants and shared types of the geopotential column block.
// ----------------------------------------------------------------------------
package hgc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int UW        = 47;                // unsigned field width
	localparam int SW        = 48;                // signed field width
	localparam int QB        = 50;                // quotient bits, cap is 2^(QB-1)
	localparam int P1W       = 2 * UW;            // rg * tv
	localparam int P2W       = 3 * UW;            // rg * tv * dp
	localparam int DW        = UW + FRAC_BITS;    // divisor p << FRAC_BITS
	localparam int NHW       = P2W - QB;          // numerator bits above quotient
	localparam int CW        = 6;                 // iteration counter
	localparam int PAW       = 4;                 // APB address width
	localparam int PDW       = 64;                // APB data width

	localparam logic [UW-1:0] GAS_RESET = UW'(18808832);

	// register index, decoded from paddr[3]
	localparam logic REG_GAS = 1'b0;

	// one queued level, classified by the front end
	typedef struct packed {
		logic                 column_start;
		logic signed [SW-1:0] surface_geopotential;
		logic [UW-1:0]        virtual_temp;
		logic [UW-1:0]        pressure;
		logic [UW-1:0]        layer_thickness;
		logic                 pressure_zero;
	} hgc_job_t;

endpackage

### rtl/hgc_channels.sv
// ----------------------------------------------------------------------------
// hgc channel interfaces
// Valid/ready channels for input levels and result beats.
// ----------------------------------------------------------------------------
interface hgc_in_if;
	import hgc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 column_start;
	logic signed [SW-1:0] surface_geopotential;
	logic [UW-1:0]        virtual_temp;
	logic [UW-1:0]        pressure;
	logic [UW-1:0]        layer_thickness;

	modport source(output valid, column_start, surface_geopotential, virtual_temp,
		pressure, layer_thickness, input ready);
	modport sink(input valid, column_start, surface_geopotential, virtual_temp,
		pressure, layer_thickness, output ready);
endinterface

interface hgc_out_if;
	import hgc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] geopotential;
	logic                 overflow;

	modport source(output valid, geopotential, overflow, input ready);
	modport sink(input valid, geopotential, overflow, output ready);
endinterface

### rtl/hgc_front.sv
// ----------------------------------------------------------------------------
// hgc_front
// Accepts level beats, flags zero pressure and queues them for the back end.
// ----------------------------------------------------------------------------
module hgc_front (
	input  logic             clk,
	input  logic             arst_n,
	hgc_in_if.sink           items,
	output hgc_pkg::hgc_job_t job,
	output logic             job_valid,
	input  logic             job_pop
);
	import hgc_pkg::*;

	hgc_job_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	hgc_job_t   cls;

	// classify incoming level
	always_comb begin
		cls.column_start         = items.column_start;
		cls.surface_geopotential = items.surface_geopotential;
		cls.virtual_temp         = items.virtual_temp;
		cls.pressure             = items.pressure;
		cls.layer_thickness      = items.layer_thickness;
		cls.pressure_zero        = (items.pressure == '0);
	end

	assign items.ready = (cnt_q != 2'd2);
	assign push        = items.valid && items.ready;
	assign job         = mem_q[rp_q];
	assign job_valid   = (cnt_q != 2'd0);

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (job_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop};
		end
	end

endmodule

### rtl/hgc_back.sv
// ----------------------------------------------------------------------------
// hgc_back
// Shift-add products, restoring divide, accumulate and saturate per level.
// ----------------------------------------------------------------------------
`include "hydrostatic_geopotential_column_defines.svh"

module hgc_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hgc_pkg::hgc_job_t        job,
	input  logic                     job_valid,
	output logic                     job_pop,
	input  logic [hgc_pkg::UW-1:0]   gas_constant,
	hgc_out_if.source                results
);
	import hgc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL1 = 6'b000010,
		S_MUL2 = 6'b000100,
		S_DCHK = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} st_t;

	localparam logic [QB-1:0]        TERM_CAP = QB'(1) << (QB - 1);
	localparam logic signed [SW+2:0] POS_MAX  = (SW + 3)'((64'd1 << (SW - 1)) - 64'd1);

	st_t                  st_q;
	logic [CW-1:0]        cnt_q;
	hgc_job_t             job_q;
	logic [P1W-1:0]       p1_q;
	logic [P2W-1:0]       p2_q;
	logic [DW-1:0]        rem_q;
	logic [QB-1:0]        nlo_q;
	logic [QB-1:0]        quo_q;
	logic                 sat_q;
	logic [UW-1:0]        acc_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] out_geo_q;
	logic                 out_ovf_q;

	logic [DW-1:0]        dvs;
	logic [UW:0]          sum1;
	logic [P1W:0]         sum2;
	logic [DW:0]          trial;
	logic                 ge;
	logic [DW:0]          diff;
	logic                 big;
	logic [QB-1:0]        term;
	logic [UW-1:0]        acc_eff;
	logic signed [SW+2:0] geo_sum;
	logic [SW+2:0]        acc_sum;
	logic                 geo_sat, acc_sat;
	logic                 out_load;

	// datapath
	always_comb begin
		dvs   = {job_q.pressure, {FRAC_BITS{1'b0}}};
		sum1  = {1'b0, p1_q[P1W-1:UW]} + (p1_q[0] ? {1'b0, gas_constant} : '0);
		sum2  = {1'b0, p2_q[P2W-1:UW]} + (p2_q[0] ? {1'b0, p1_q} : '0);
		trial = {rem_q, nlo_q[QB-1]};
		ge    = (trial >= {1'b0, dvs});
		diff  = trial - {1'b0, dvs};
		big   = (p2_q[P2W-1:QB] >= {{(NHW - DW){1'b0}}, dvs});
	end

	// layer term, running sum and saturation
	always_comb begin
		if (sat_q || job_q.pressure_zero) begin
			term = TERM_CAP;
		end else if (quo_q > TERM_CAP) begin
			term = TERM_CAP;
		end else begin
			term = quo_q;
		end
		acc_eff = job_q.column_start ? '0 : acc_q;
		geo_sum = $signed({{3{job_q.surface_geopotential[SW-1]}}, job_q.surface_geopotential})
			+ $signed({4'b0, acc_eff}) + $signed({2'b0, term[QB-1:1]});
		acc_sum = {4'b0, acc_eff} + {1'b0, term};
		geo_sat = (geo_sum > POS_MAX);
		acc_sat = |acc_sum[SW+2:UW];
	end

	assign job_pop  = (st_q == S_IDLE) && job_valid;
	assign out_load = (st_q == S_DONE) && (!out_valid_q || results.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cnt_q <= '0;
			sat_q <= 1'b0;
			acc_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						sat_q <= 1'b0;
						cnt_q <= '0;
						st_q  <= job.pressure_zero ? S_DONE : S_MUL1;
					end
				end
				S_MUL1: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(UW - 1)) begin
						cnt_q <= '0;
						st_q  <= S_MUL2;
					end
				end
				S_MUL2: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(UW - 1)) begin
						cnt_q <= '0;
						st_q  <= S_DCHK;
					end
				end
				S_DCHK: begin
					sat_q <= big;
					st_q  <= big ? S_DONE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QB - 1)) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						acc_q <= acc_sat ? {UW{1'b1}} : acc_sum[UW-1:0];
						st_q  <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			p1_q  <= {{UW{1'b0}}, job.virtual_temp};
		end
		if (st_q == S_MUL1) begin
			p1_q <= {sum1, p1_q[UW-1:1]};
			if (cnt_q == CW'(UW - 1)) begin
				p2_q <= {{P1W{1'b0}}, job_q.layer_thickness};
			end
		end
		if (st_q == S_MUL2) begin
			p2_q <= {sum2, p2_q[UW-1:1]};
		end
		if (st_q == S_DCHK) begin
			rem_q <= p2_q[QB+DW-1:QB];
			nlo_q <= p2_q[QB-1:0];
			quo_q <= '0;
		end
		if (st_q == S_DIV) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[QB-2:0], ge};
			nlo_q <= {nlo_q[QB-2:0], 1'b0};
		end
		if (out_load) begin
			out_geo_q <= geo_sat ? POS_MAX[SW-1:0] : geo_sum[SW-1:0];
			out_ovf_q <= job_q.pressure_zero || geo_sat || acc_sat;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.geopotential = out_geo_q;
	assign results.overflow     = out_ovf_q;

	`HGC_ASSERT_IMP(a_pop_idle, job_pop, st_q == S_IDLE && job_valid, "pop outside idle")
	`HGC_ASSERT_IMP(a_rem_below, st_q == S_DIV, rem_q < dvs, "remainder not below divisor")
	`HGC_ASSERT_NEXT(a_done_hold, st_q == S_DONE && out_valid_q && !results.ready, st_q == S_DONE, "result lost under stall")

endmodule

### rtl/hydrostatic_geopotential_column.sv
// ----------------------------------------------------------------------------
// hydrostatic_geopotential_column
// Integrates mid-level geopotential up a column, one result beat per level.
// ----------------------------------------------------------------------------
// Levels go in bottom first; column_start clears the running interface sum.
// A level with non-zero pressure passes through the back end in order: it is
// taken from the queue, the shift-add Rgas*Tv product is formed, then the
// product with dp, a range check runs and the restoring divide follows, and
// the result register is written last; a level whose layer term is found out
// of range at the check skips the divide, and a zero-pressure level goes
// straight to the result write. A stalled result register holds the back end
// in its last state until the beat leaves. The back end has a single
// shift-add multiplier and divider. A two-beat queue lets the input
// side run ahead of the arithmetic. The gas constant sits at byte address 0
// of the APB port (64-bit data) and must only be written idle.
module hydrostatic_geopotential_column (
	input  logic                      clk,
	input  logic                      arst_n,
	hgc_in_if.sink                    items,
	hgc_out_if.source                 results,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hgc_pkg::PAW-1:0]   paddr,
	input  logic [hgc_pkg::PDW-1:0]   pwdata,
	output logic [hgc_pkg::PDW-1:0]   prdata,
	output logic                      pready
);
	import hgc_pkg::*;

	logic [UW-1:0] gas_q;
	hgc_job_t      job;
	logic          job_valid;
	logic          job_pop;

	assign pready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_q <= GAS_RESET;
		end else if (psel && penable && pwrite && (paddr[3] == REG_GAS)) begin
			gas_q <= pwdata[UW-1:0];
		end
	end

	// read back
	always_comb begin
		unique case (paddr[3])
			REG_GAS: prdata = {{(PDW - UW){1'b0}}, gas_q};
			default: prdata = '0;
		endcase
	end

	hgc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.job       (job),
		.job_valid (job_valid),
		.job_pop   (job_pop)
	);

	hgc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.job_valid    (job_valid),
		.job_pop      (job_pop),
		.gas_constant (gas_q),
		.results      (results)
	);

endmodule

### test/hgc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Geopotential column checker
// Watches the level and result channels and the APB port, predicts each
// mid-level geopotential beat and compares it field by field.
// ----------------------------------------------------------------------------
module hgc_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	hgc_in_if                       items,
	hgc_out_if                      results,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [hgc_pkg::PAW-1:0] paddr,
	input  logic [hgc_pkg::PDW-1:0] pwdata,
	input  logic                    pready,
	output int                      errors,
	output int                      pending
);
	import hgc_pkg::*;

	typedef struct packed {
		logic signed [SW-1:0] geopotential;
		logic                 overflow;
	} geo_beat_t;

	localparam logic [UW-1:0] ACC_MAX  = {UW{1'b1}};
	localparam logic [49:0]   TERM_MAX = 50'h2_0000_0000_0000;

	geo_beat_t     geo_expected[$];
	logic [UW-1:0] rgas;
	logic [UW-1:0] column_sum;

	assign pending = geo_expected.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// one level: layer term Rgas*Tv*dp/p, half of it on top of the running sum
	task automatic predict_level();
		logic [140:0]         num;
		logic [140:0]         den;
		logic [140:0]         quo;
		logic [49:0]          term;
		logic signed [51:0]   total;
		logic [50:0]          acc_next;
		geo_beat_t            b;
		if (items.column_start) column_sum = '0;
		b.overflow = 1'b0;
		if (items.pressure == '0) begin
			term       = TERM_MAX;
			b.overflow = 1'b1;
		end else begin
			num  = 141'(rgas) * 141'(items.virtual_temp) * 141'(items.layer_thickness);
			den  = 141'(items.pressure) << FRAC_BITS;
			quo  = num / den;
			term = (quo > 141'(TERM_MAX)) ? TERM_MAX : quo[49:0];
		end
		total = 52'(items.surface_geopotential) + $signed({5'b0, column_sum})
			+ $signed({3'b0, term[49:1]});
		if (total > $signed({5'b0, ACC_MAX})) begin
			total      = {5'b0, ACC_MAX};
			b.overflow = 1'b1;
		end
		b.geopotential = total[SW-1:0];
		acc_next = 51'(column_sum) + 51'(term);
		if (acc_next > 51'(ACC_MAX)) begin
			acc_next   = 51'(ACC_MAX);
			b.overflow = 1'b1;
		end
		column_sum = acc_next[UW-1:0];
		geo_expected.push_back(b);
	endtask

	always @(posedge clk or negedge arst_n) begin
		geo_beat_t w;
		if (!arst_n) begin
			rgas       = GAS_RESET;
			column_sum = '0;
			errors     = 0;
			geo_expected.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready && paddr[3] == REG_GAS)
				rgas = pwdata[UW-1:0];
			// result beats
			if (results.valid && results.ready) begin
				if (geo_expected.size() == 0) begin
					report("unexpected beat", 64'(results.geopotential), 64'd0);
				end else begin
					w = geo_expected.pop_front();
					if (results.geopotential !== w.geopotential)
						report("geopotential", 64'(results.geopotential), 64'(w.geopotential));
					if (results.overflow !== w.overflow)
						report("overflow", 64'(results.overflow), 64'(w.overflow));
				end
			end
			// level beats
			if (items.valid && items.ready) predict_level();
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Geopotential column testbench
// Drives columns of levels with random gaps and back-pressure through
// several gas constant settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import hgc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [UW-1:0] UMAX = {UW{1'b1}};

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PAW-1:0] paddr = '0;
	logic [PDW-1:0] pwdata = '0;
	logic [PDW-1:0] prdata;
	logic           pready;
	int             errors, pending;
	int             cycles = 0;
	int             stall_left = 0;
	logic           calm = 1'b0;

	hgc_in_if  items();
	hgc_out_if results();

	hydrostatic_geopotential_column uut (
		.clk, .arst_n, .items(items.sink), .results(results.source),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	hgc_checker chk (
		.clk, .arst_n, .items, .results, .psel, .penable, .pwrite, .paddr, .pwdata,
		.pready, .errors, .pending
	);

	always #5 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (calm || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			stall_left    <= 0;
		end else if (stall_left > 0) begin
			results.ready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else begin
			results.ready <= 1'b1;
			stall_left    <= gap_len();
		end
	end

	task automatic apb_write(input logic [PAW-1:0] addr, input logic [PDW-1:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic send_level(input logic cs, input logic [SW-1:0] phis, input logic [UW-1:0] tv,
		input logic [UW-1:0] p, input logic [UW-1:0] dp);
		int g;
		items.valid                <= 1'b1;
		items.column_start         <= cs;
		items.surface_geopotential <= phis;
		items.virtual_temp         <= tv;
		items.pressure             <= p;
		items.layer_thickness      <= dp;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		g = gap_len();
		if (g > 0) begin
			items.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// drain, then let the back end settle before a register write
	task automatic settle();
		items.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [UW-1:0] rnd47();
		return UW'({$urandom(), $urandom()});
	endfunction

	// mostly physical-looking values, sometimes full-range noise
	function automatic logic [UW-1:0] field(input int lo, input int hi);
		if ($urandom_range(3) == 0) return rnd47() >> $urandom_range(46);
		return UW'($urandom_range(lo, hi)) << FRAC_BITS;
	endfunction

	task automatic random_columns(input int n);
		int  left;
		logic [UW-1:0] p;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) left = $urandom_range(1, 12);
			p = field(100, 100000);
			if ($urandom_range(29) == 0) p = '0;
			send_level(left == 1 ? 1'b0 : ($urandom_range(19) == 0 ? 1'b0 : 1'b1) & (i == 0 ||
				left == 0) | ($urandom_range(9) == 0),
				$urandom_range(3) == 0 ? SW'({$urandom(), $urandom()}) : SW'($signed(
				$urandom_range(0, 40000) - 20000)) <<< FRAC_BITS,
				field(150, 350), p, field(1, 5000));
			left--;
		end
	endtask

	initial begin
		items.valid <= 1'b0;
		items.column_start <= 1'b0;
		items.surface_geopotential <= '0;
		items.virtual_temp <= '0;
		items.pressure <= '0;
		items.layer_thickness <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset gas constant, extremes and special cases
		calm = 1'b1;
		send_level(1'b1, '0, UW'(300) << FRAC_BITS, UW'(50000) << FRAC_BITS,
			UW'(1000) << FRAC_BITS);
		send_level(1'b0, {1'b1, {(SW-1){1'b0}}}, UW'(250) << FRAC_BITS,
			UW'(30000) << FRAC_BITS, UW'(2000) << FRAC_BITS);
		send_level(1'b0, {1'b0, {(SW-1){1'b1}}}, UW'(250) << FRAC_BITS,
			UW'(30000) << FRAC_BITS, UW'(2000) << FRAC_BITS);
		send_level(1'b0, '0, UMAX, '0, UMAX);
		send_level(1'b1, '0, UMAX, UW'(1), UMAX);
		send_level(1'b1, {SW{1'b1}}, '0, UMAX, UMAX);
		send_level(1'b0, '0, UMAX, UMAX, '0);
		send_level(1'b0, '0, UMAX, UMAX, UMAX);
		send_level(1'b1, {1'b1, {(SW-1){1'b0}}}, UMAX, UW'(1), UMAX);
		calm = 1'b0;
		random_columns(130);

		settle();
		apb_write(4'd0, 64'd0);
		send_level(1'b1, '0, UMAX, UW'(1), UMAX);
		send_level(1'b0, '0, UMAX, '0, UMAX);
		random_columns(60);

		settle();
		apb_write(4'd0, 64'(UMAX));
		send_level(1'b1, '0, UMAX, UMAX, UMAX);
		send_level(1'b1, '0, UW'(1), UMAX, UW'(1));
		random_columns(80);

		settle();
		apb_write(4'd0, 64'(rnd47()));
		calm = 1'b1;
		random_columns(60);
		calm = 1'b0;
		random_columns(80);

		settle();
		apb_write(4'd0, 64'(GAS_RESET));
		random_columns(90);

		items.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
